// ===== design/gcb_pkg.sv =====
// Shared types, constants and helper functions for the glyph coverage blit.
// Used by gcb_fe, gcb_fifo, gcb_be and glyph_coverage_blend_blit.
package gcb_pkg;

  // Canvas size limit; larger register values saturate to it.
  localparam int MAX_DIM = 256;

  // Configuration register indexes.
  localparam logic [2:0] REG_OFFSET_X      = 3'd0;
  localparam logic [2:0] REG_OFFSET_Y      = 3'd1;
  localparam logic [2:0] REG_CANVAS_WIDTH  = 3'd2;
  localparam logic [2:0] REG_CANVAS_HEIGHT = 3'd3;
  localparam logic [2:0] REG_TEXT_COLOR    = 3'd4;
  localparam logic [2:0] REG_BLEND_MODE    = 3'd5;

  // Queue between front and back.
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  // Divider: eight quotient bits, two per stage.
  localparam int QUOT_W      = 8;
  localparam int STEPS_STAGE = 2;
  localparam int DIV_STAGES  = QUOT_W / STEPS_STAGE;

  localparam int NUM_CH = 4;  // red, green, blue, alpha

  typedef struct packed {
    logic signed [8:0] offset_x;
    logic signed [8:0] offset_y;
    logic [8:0]        canvas_width;
    logic [8:0]        canvas_height;
    logic [23:0]       text_color;
    logic              blend_mode;
  } cfg_t;

  typedef enum logic [1:0] {
    KIND_PASS = 2'd0,
    KIND_TINT = 2'd1,
    KIND_MIX  = 2'd2
  } kind_e;

  // One classified word as it travels from front to back.
  typedef struct packed {
    kind_e       kind;
    logic        we;
    logic [15:0] idx;
    logic [7:0]  cov;
    logic [7:0]  dst_r;
    logic [7:0]  dst_g;
    logic [7:0]  dst_b;
    logic [7:0]  dst_a;
  } entry_t;

  // Partial remainder and the shifting dividend/quotient word.
  typedef struct packed {
    logic [8:0] rem;
    logic [7:0] lo;
  } div_st_t;

  // One restoring division step: shift in the next dividend bit, subtract if it fits.
  function automatic div_st_t div_step(div_st_t s, logic [8:0] dv);
    logic [9:0] r2;
    logic       qb;
    div_st_t    o;
    r2 = {s.rem, s.lo[7]};
    qb = (r2 >= {1'b0, dv});
    if (qb) begin
      o.rem = 9'(r2 - {1'b0, dv});
    end else begin
      o.rem = r2[8:0];
    end
    o.lo = {s.lo[6:0], qb};
    return o;
  endfunction

  // Saturate a canvas dimension register to MAX_DIM.
  function automatic logic [8:0] clamp_dim(logic [8:0] v);
    if (v > 9'(MAX_DIM)) begin
      return 9'(MAX_DIM);
    end
    return v;
  endfunction

endpackage

// ===== design/gcb_fe.sv =====
// Front end: places the sample on the canvas, clips it, forms the index
// and classifies the word for the back end. Depends on gcb_pkg.
module gcb_fe (
  input  gcb_pkg::cfg_t   cfg_i,
  input  logic [7:0]      glyph_row_i,
  input  logic [7:0]      glyph_col_i,
  input  logic [7:0]      coverage_i,
  input  logic [7:0]      dst_red_i,
  input  logic [7:0]      dst_green_i,
  input  logic [7:0]      dst_blue_i,
  input  logic [7:0]      dst_alpha_i,
  output gcb_pkg::entry_t entry_o
);

  logic [8:0]        w;
  logic [8:0]        h;
  logic signed [9:0] x;
  logic signed [9:0] y;
  logic              in_canvas;
  logic [16:0]       prod;
  logic [15:0]       idx;

  always_comb begin
    w         = gcb_pkg::clamp_dim(cfg_i.canvas_width);
    h         = gcb_pkg::clamp_dim(cfg_i.canvas_height);
    x         = $signed({2'b00, glyph_col_i}) + 10'(cfg_i.offset_x);
    y         = $signed({2'b00, glyph_row_i}) + 10'(cfg_i.offset_y);
    in_canvas = !x[9] && (x[8:0] < w) && !y[9] && (y[8:0] < h);
    // Row below h <= MAX_DIM, so eight bits of y carry it inside the canvas.
    prod      = 17'(y[7:0] * w);
    idx       = 16'(prod + 17'(x[8:0]));
  end

  always_comb begin
    entry_o.cov   = coverage_i;
    entry_o.dst_r = dst_red_i;
    entry_o.dst_g = dst_green_i;
    entry_o.dst_b = dst_blue_i;
    entry_o.dst_a = dst_alpha_i;
    if (!in_canvas) begin
      entry_o.kind = gcb_pkg::KIND_PASS;
      entry_o.we   = 1'b0;
      entry_o.idx  = '0;
    end else if (!cfg_i.blend_mode) begin
      entry_o.kind = gcb_pkg::KIND_TINT;
      entry_o.we   = 1'b1;
      entry_o.idx  = idx;
    end else if (coverage_i != 8'd0) begin
      entry_o.kind = gcb_pkg::KIND_MIX;
      entry_o.we   = 1'b1;
      entry_o.idx  = idx;
    end else begin
      entry_o.kind = gcb_pkg::KIND_PASS;
      entry_o.we   = 1'b0;
      entry_o.idx  = idx;
    end
  end

endmodule

// ===== design/gcb_fifo.sv =====
// Short queue of classified words between front and back end.
// Depends on gcb_pkg for the word type and depth.
module gcb_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  gcb_pkg::entry_t wdata_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output gcb_pkg::entry_t rdata_o
);

  gcb_pkg::entry_t            mem_q [gcb_pkg::FIFO_DEPTH];
  logic [gcb_pkg::FIFO_AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [gcb_pkg::FIFO_AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [gcb_pkg::FIFO_AW:0]   count_q, count_d;
  logic                        do_push;
  logic                        do_pop;

  assign full_o  = (count_q == (gcb_pkg::FIFO_AW+1)'(gcb_pkg::FIFO_DEPTH));
  assign empty_o = (count_q == '0);
  assign rdata_o = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

// ===== design/gcb_be.sv =====
// Back end: forms numerator and divisor per channel, then a pipelined
// restoring divider gives the exact floor. Depends on gcb_pkg.
module gcb_be (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  gcb_pkg::cfg_t   cfg_i,
  input  logic            empty_i,
  input  gcb_pkg::entry_t entry_i,
  output logic            pop_o,
  output logic            m_valid_o,
  input  logic            m_ready_i,
  output logic            we_o,
  output logic [15:0]     idx_o,
  output logic [7:0]      new_red_o,
  output logic [7:0]      new_green_o,
  output logic [7:0]      new_blue_o,
  output logic [7:0]      new_alpha_o
);

  localparam int NS = gcb_pkg::DIV_STAGES;

  logic                  vld_q [NS+1];
  logic                  we_q  [NS+1];
  logic [15:0]           idx_q [NS+1];
  logic [8:0]            dv_q  [NS];
  logic [16:0]           num_q [gcb_pkg::NUM_CH];
  gcb_pkg::div_st_t      st_q  [1:NS][gcb_pkg::NUM_CH];
  gcb_pkg::div_st_t      st_d  [1:NS][gcb_pkg::NUM_CH];

  logic                  adv;
  logic [7:0]            dch   [gcb_pkg::NUM_CH];
  logic [7:0]            tch   [gcb_pkg::NUM_CH];
  logic [16:0]           num_d [gcb_pkg::NUM_CH];
  logic [8:0]            dv_d;
  logic [7:0]            f1;
  logic [7:0]            cov;
  logic [7:0]            amax;

  // Advance the whole pipe unless the output word is held.
  assign adv   = !vld_q[NS] || m_ready_i;
  assign pop_o = adv && !empty_i;

  always_comb begin
    dch[0] = entry_i.dst_r;
    dch[1] = entry_i.dst_g;
    dch[2] = entry_i.dst_b;
    dch[3] = entry_i.dst_a;
    tch[0] = cfg_i.text_color[23:16];
    tch[1] = cfg_i.text_color[15:8];
    tch[2] = cfg_i.text_color[7:0];
    tch[3] = '0;
    cov    = entry_i.cov;
    amax   = (cov > entry_i.dst_a) ? cov : entry_i.dst_a;
    f1     = '0;
    dv_d   = 9'd1;
    for (int ch = 0; ch < gcb_pkg::NUM_CH; ch++) begin
      num_d[ch] = 17'(dch[ch]);
    end
    unique case (entry_i.kind)
      gcb_pkg::KIND_TINT: begin
        f1   = 8'hff - cov;
        dv_d = 9'd255;
        for (int ch = 0; ch < gcb_pkg::NUM_CH - 1; ch++) begin
          num_d[ch] = 17'(f1 * dch[ch]) + 17'(cov * tch[ch]);
        end
        // Alpha takes the larger of coverage and destination: scale it by 255
        // so the shared divide by 255 hands it back unchanged.
        num_d[3] = 17'(amax * 8'hff);
      end
      gcb_pkg::KIND_MIX: begin
        f1   = entry_i.dst_a;
        dv_d = 9'(cov) + 9'(entry_i.dst_a);
        for (int ch = 0; ch < gcb_pkg::NUM_CH; ch++) begin
          num_d[ch] = 17'(f1 * dch[ch]) + 17'(cov * cov);
        end
      end
      gcb_pkg::KIND_PASS: begin
        dv_d = 9'd1;
      end
      default: begin
        dv_d = 9'd1;
      end
    endcase
  end

  // Each stage runs two division steps; quotient stays below 256 in every mode.
  always_comb begin
    gcb_pkg::div_st_t s;
    for (int k = 1; k <= NS; k++) begin
      for (int ch = 0; ch < gcb_pkg::NUM_CH; ch++) begin
        if (k == 1) begin
          s.rem = num_q[ch][16:8];
          s.lo  = num_q[ch][7:0];
        end else begin
          s = st_q[k-1][ch];
        end
        for (int j = 0; j < gcb_pkg::STEPS_STAGE; j++) begin
          s = gcb_pkg::div_step(s, dv_q[k-1]);
        end
        st_d[k][ch] = s;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= NS; k++) begin
        vld_q[k] <= 1'b0;
      end
    end else if (adv) begin
      vld_q[0] <= !empty_i;
      for (int k = 1; k <= NS; k++) begin
        vld_q[k] <= vld_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      we_q[0]  <= entry_i.we;
      idx_q[0] <= entry_i.idx;
      dv_q[0]  <= dv_d;
      for (int ch = 0; ch < gcb_pkg::NUM_CH; ch++) begin
        num_q[ch] <= num_d[ch];
      end
      for (int k = 1; k <= NS; k++) begin
        we_q[k]  <= we_q[k-1];
        idx_q[k] <= idx_q[k-1];
        if (k < NS) begin
          dv_q[k] <= dv_q[k-1];
        end
        for (int ch = 0; ch < gcb_pkg::NUM_CH; ch++) begin
          st_q[k][ch] <= st_d[k][ch];
        end
      end
    end
  end

  assign m_valid_o   = vld_q[NS];
  assign we_o        = we_q[NS];
  assign idx_o       = idx_q[NS];
  assign new_red_o   = st_q[NS][0].lo;
  assign new_green_o = st_q[NS][1].lo;
  assign new_blue_o  = st_q[NS][2].lo;
  assign new_alpha_o = st_q[NS][3].lo;

endmodule

// ===== design/glyph_coverage_blend_blit.sv =====
// Top level of the glyph coverage blit: configuration registers, front end,
// word queue and dividing back end. Depends on gcb_pkg, gcb_fe, gcb_fifo, gcb_be.
//
//   channel   | direction | handshake                    | payload
//   s_axis    | in        | s_axis_tvalid_i/tready_o     | sample and destination RGBA
//   m_axis    | out       | m_axis_tvalid_o/tready_i     | write enable, index, new RGBA
//   cfg       | in        | cfg_we_i                     | cfg_idx_i, cfg_wdata_i
//
// One word in and one word out per clock when the sink keeps up. From input to
// output a word passes the queue, then the back end: numerator stage plus four
// two-bit divider stages.
// Reset clears the queue, the pipe valid bits and loads the register defaults.
// A held output word freezes the back end; the queue of four absorbs the
// stall so the input side keeps taking words until it fills.
module glyph_coverage_blend_blit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // cfg port
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [23:0] cfg_wdata_i,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // glyph_row[7:0], glyph_col[15:8], coverage[23:16], dst_red[31:24],
  // dst_green[39:32], dst_blue[47:40], dst_alpha[55:48]
  input  logic [55:0] s_axis_tdata,
  // output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // write_enable[0], pixel_index[16:1], new_red[24:17], new_green[32:25],
  // new_blue[40:33], new_alpha[48:41], zero[55:49]
  output logic [55:0] m_axis_tdata
);

  gcb_pkg::cfg_t   cfg_q;
  gcb_pkg::entry_t fe_entry;
  gcb_pkg::entry_t q_entry;
  logic            q_full;
  logic            q_empty;
  logic            q_pop;
  logic            be_we;
  logic [15:0]     be_idx;
  logic [7:0]      be_r;
  logic [7:0]      be_g;
  logic [7:0]      be_b;
  logic [7:0]      be_a;

  // Register file: write by index, ignore indexes beyond the list.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.offset_x      <= '0;
      cfg_q.offset_y      <= '0;
      cfg_q.canvas_width  <= 9'd48;
      cfg_q.canvas_height <= 9'd48;
      cfg_q.text_color    <= 24'hffffff;
      cfg_q.blend_mode    <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        gcb_pkg::REG_OFFSET_X:      cfg_q.offset_x      <= $signed(cfg_wdata_i[8:0]);
        gcb_pkg::REG_OFFSET_Y:      cfg_q.offset_y      <= $signed(cfg_wdata_i[8:0]);
        gcb_pkg::REG_CANVAS_WIDTH:  cfg_q.canvas_width  <= cfg_wdata_i[8:0];
        gcb_pkg::REG_CANVAS_HEIGHT: cfg_q.canvas_height <= cfg_wdata_i[8:0];
        gcb_pkg::REG_TEXT_COLOR:    cfg_q.text_color    <= cfg_wdata_i;
        gcb_pkg::REG_BLEND_MODE:    cfg_q.blend_mode    <= cfg_wdata_i[0];
        default: begin
        end
      endcase
    end
  end

  // Accept whenever the queue has room.
  assign s_axis_tready = !q_full;

  gcb_fe u_fe (
    .cfg_i       (cfg_q),
    .glyph_row_i (s_axis_tdata[7:0]),
    .glyph_col_i (s_axis_tdata[15:8]),
    .coverage_i  (s_axis_tdata[23:16]),
    .dst_red_i   (s_axis_tdata[31:24]),
    .dst_green_i (s_axis_tdata[39:32]),
    .dst_blue_i  (s_axis_tdata[47:40]),
    .dst_alpha_i (s_axis_tdata[55:48]),
    .entry_o     (fe_entry)
  );

  gcb_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (s_axis_tvalid),
    .wdata_i (fe_entry),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .rdata_o (q_entry)
  );

  gcb_be u_be (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .empty_i     (q_empty),
    .entry_i     (q_entry),
    .pop_o       (q_pop),
    .m_valid_o   (m_axis_tvalid),
    .m_ready_i   (m_axis_tready),
    .we_o        (be_we),
    .idx_o       (be_idx),
    .new_red_o   (be_r),
    .new_green_o (be_g),
    .new_blue_o  (be_b),
    .new_alpha_o (be_a)
  );

  assign m_axis_tdata = {7'd0, be_a, be_b, be_g, be_r, be_idx, be_we};

endmodule

// ===== test/tb.sv =====
// Self-checking bench for glyph_coverage_blend_blit: directed and random glyph
// samples against a local pixel predictor, with stalls on both stream sides.
// Depends on gcb_pkg for the register indexes and the cfg_t register layout.
module tb;

  // Generous ceiling for the whole run.
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int MAX_PRINTS = 30;

  // One glyph coverage sample with the destination pixel it lands on.
  typedef struct packed {
    logic [7:0] row;
    logic [7:0] col;
    logic [7:0] cov;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } sample_t;

  // One canvas update as the block reports it.
  typedef struct packed {
    logic        we;
    logic [15:0] idx;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
  } pixel_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = gcb_pkg::REG_OFFSET_X;
  logic [23:0] cfg_wdata_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // glyph_row[7:0], glyph_col[15:8], coverage[23:16], dst_red[31:24],
  // dst_green[39:32], dst_blue[47:40], dst_alpha[55:48]
  logic [55:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // write_enable[0], pixel_index[16:1], new_red[24:17], new_green[32:25],
  // new_blue[40:33], new_alpha[48:41], zero[55:49]
  logic [55:0] m_axis_tdata;

  // Local copy of the register file, kept in step with every write.
  gcb_pkg::cfg_t shadow_cfg = '{offset_x: 9'sd0, offset_y: 9'sd0, canvas_width: 9'd48,
                                canvas_height: 9'd48, text_color: 24'hffffff,
                                blend_mode: 1'b0};

  pixel_t      pending_pixels[$];
  int          mismatch_count = 0;
  int unsigned cycle_count = 0;

  // Idle rates in percent; the receiver also honours long hold-off requests.
  int send_idle_pct = 18;
  int recv_idle_pct = 66;
  int hold_len = 0;
  int hold_seq = 0;
  int hold_seen = 0;
  int hold_left = 0;

  glyph_coverage_blend_blit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  // Watchdog: end the run if the stream ever locks up.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // ------------------------------------------------------------------------
  // Predictor
  // ------------------------------------------------------------------------

  // Canvas sizes above the limit saturate; zero stays zero (nothing inside).
  function automatic int eff_dim(logic [8:0] v);
    return (v > 9'd256) ? 256 : int'(v);
  endfunction

  // Tint: mix destination toward the text colour by coverage / 255, floored.
  function automatic logic [7:0] tint_level(int d, int t, int c);
    return 8'(((255 - c) * d + c * t) / 255);
  endfunction

  // Blend: weight destination by its alpha and coverage by itself, floored.
  function automatic logic [7:0] mix_level(int d, int a, int c);
    return 8'((a * d + c * c) / (c + a));
  endfunction

  function automatic pixel_t predict_pixel(sample_t s);
    int     w;
    int     h;
    int     x;
    int     y;
    int     c;
    int     a;
    pixel_t p;
    w = eff_dim(shadow_cfg.canvas_width);
    h = eff_dim(shadow_cfg.canvas_height);
    x = int'(s.col) + int'($signed(shadow_cfg.offset_x));
    y = int'(s.row) + int'($signed(shadow_cfg.offset_y));
    c = int'(s.cov);
    a = int'(s.alpha);
    // Default: pass the destination through untouched.
    p = '{we: 1'b0, idx: 16'd0, red: s.red, green: s.green, blue: s.blue,
          alpha: s.alpha};
    if (x >= 0 && x < w && y >= 0 && y < h) begin
      p.idx = 16'(y * w + x);
      if (!shadow_cfg.blend_mode) begin
        // Tint writes even with zero coverage.
        p.we    = 1'b1;
        p.red   = tint_level(int'(s.red), int'(shadow_cfg.text_color[23:16]), c);
        p.green = tint_level(int'(s.green), int'(shadow_cfg.text_color[15:8]), c);
        p.blue  = tint_level(int'(s.blue), int'(shadow_cfg.text_color[7:0]), c);
        p.alpha = (s.cov > s.alpha) ? s.cov : s.alpha;
      end else if (c > 0) begin
        // Blend skips empty coverage but still reports the index.
        p.we    = 1'b1;
        p.red   = mix_level(int'(s.red), a, c);
        p.green = mix_level(int'(s.green), a, c);
        p.blue  = mix_level(int'(s.blue), a, c);
        p.alpha = mix_level(a, a, c);
      end
    end
    return p;
  endfunction

  // ------------------------------------------------------------------------
  // Result checking
  // ------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatch_count < MAX_PRINTS) begin
      $display("[%0d] mismatch on %s: got %0d, expected %0d", cycle_count, what, got,
               want);
    end
    mismatch_count++;
  endtask

  // Compare every accepted output word with the oldest outstanding prediction.
  always @(posedge clk_i) begin : result_check
    pixel_t got;
    pixel_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = '{we: m_axis_tdata[0], idx: m_axis_tdata[16:1], red: m_axis_tdata[24:17],
              green: m_axis_tdata[32:25], blue: m_axis_tdata[40:33],
              alpha: m_axis_tdata[48:41]};
      if (pending_pixels.size() == 0) begin
        report_mismatch("unexpected word, pixel index", int'(got.idx), -1);
      end else begin
        want = pending_pixels.pop_front();
        if (got.we !== want.we) report_mismatch("write_enable", got.we, want.we);
        if (got.idx !== want.idx) report_mismatch("pixel_index", got.idx, want.idx);
        if (got.red !== want.red) report_mismatch("new_red", got.red, want.red);
        if (got.green !== want.green) report_mismatch("new_green", got.green, want.green);
        if (got.blue !== want.blue) report_mismatch("new_blue", got.blue, want.blue);
        if (got.alpha !== want.alpha) report_mismatch("new_alpha", got.alpha, want.alpha);
      end
    end
  end

  // Output side: long hold-offs take priority over the random stall rate.
  always @(posedge clk_i) begin
    if (hold_seq != hold_seen) begin
      hold_seen     <= hold_seq;
      hold_left     <= hold_len - 1;
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // ------------------------------------------------------------------------
  // Shared stimulus tasks
  // ------------------------------------------------------------------------

  // Offer one sample; record its prediction on the edge that accepts it.
  // The valid is left high so a following word can go out back to back.
  task automatic push_sample(input sample_t s);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {s.alpha, s.blue, s.green, s.red, s.cov, s.col, s.row};
    do @(posedge clk_i); while (!s_axis_tready);
    pending_pixels.push_back(predict_pixel(s));
  endtask

  // Drop the valid and hold until every predicted word has come back.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
  endtask

  // Write all six registers back to back; only call with the block drained.
  task automatic set_config(input gcb_pkg::cfg_t c);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= gcb_pkg::REG_OFFSET_X;
    cfg_wdata_i <= {15'd0, c.offset_x};
    @(posedge clk_i);
    cfg_idx_i   <= gcb_pkg::REG_OFFSET_Y;
    cfg_wdata_i <= {15'd0, c.offset_y};
    @(posedge clk_i);
    cfg_idx_i   <= gcb_pkg::REG_CANVAS_WIDTH;
    cfg_wdata_i <= {15'd0, c.canvas_width};
    @(posedge clk_i);
    cfg_idx_i   <= gcb_pkg::REG_CANVAS_HEIGHT;
    cfg_wdata_i <= {15'd0, c.canvas_height};
    @(posedge clk_i);
    cfg_idx_i   <= gcb_pkg::REG_TEXT_COLOR;
    cfg_wdata_i <= c.text_color;
    @(posedge clk_i);
    cfg_idx_i   <= gcb_pkg::REG_BLEND_MODE;
    cfg_wdata_i <= {23'd0, c.blend_mode};
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    shadow_cfg = c;
    @(posedge clk_i);
  endtask

  function automatic sample_t make_sample(logic [7:0] row, logic [7:0] col,
                                          logic [7:0] cov, logic [7:0] red,
                                          logic [7:0] green, logic [7:0] blue,
                                          logic [7:0] alpha);
    return '{row: row, col: col, cov: cov, red: red, green: green, blue: blue,
             alpha: alpha};
  endfunction

  function automatic logic [8:0] pick_offset();
    case ($urandom_range(9))
      0:       return 9'h100;  // most negative
      1:       return 9'h0ff;  // most positive
      2, 3:    return 9'($urandom);
      default: return 9'(int'($urandom_range(64)) - 32);
    endcase
  endfunction

  function automatic logic [8:0] pick_dim();
    case ($urandom_range(19))
      0:       return 9'd0;                        // empty canvas
      1, 2:    return 9'($urandom_range(511, 257)); // saturates
      3:       return 9'd256;
      4:       return 9'd1;
      5, 6:    return 9'($urandom_range(4, 1));
      default: return 9'($urandom_range(256, 1));
    endcase
  endfunction

  function automatic gcb_pkg::cfg_t random_config(logic mode);
    gcb_pkg::cfg_t c;
    c.offset_x      = pick_offset();
    c.offset_y      = pick_offset();
    c.canvas_width  = pick_dim();
    c.canvas_height = pick_dim();
    c.text_color    = 24'($urandom);
    c.blend_mode    = mode;
    return c;
  endfunction

  // Aim most samples near the canvas so that both clip edges and the
  // interior get plenty of traffic; the rest land anywhere.
  function automatic sample_t random_sample();
    sample_t s;
    int      tx;
    int      ty;
    s = sample_t'(56'({$urandom, $urandom}));
    if ($urandom_range(99) < 80) begin
      tx = int'($urandom_range(eff_dim(shadow_cfg.canvas_width) + 7)) - 4
           - int'($signed(shadow_cfg.offset_x));
      ty = int'($urandom_range(eff_dim(shadow_cfg.canvas_height) + 7)) - 4
           - int'($signed(shadow_cfg.offset_y));
      if (tx >= 0 && tx <= 255) s.col = 8'(tx);
      if (ty >= 0 && ty <= 255) s.row = 8'(ty);
    end
    case ($urandom_range(9))
      0: s.cov = 8'h00;
      1: s.cov = 8'hff;
      default: ;
    endcase
    case ($urandom_range(9))
      0: s.alpha = 8'h00;
      1: s.alpha = 8'hff;
      default: ;
    endcase
    return s;
  endfunction

  // ------------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------------

  // Register defaults: 48 x 48 canvas, white tint, no offset.
  task automatic test_reset_defaults();
    push_sample(make_sample(8'd0, 8'd0, 8'hff, 8'h00, 8'h00, 8'h00, 8'h00));
    push_sample(make_sample(8'd47, 8'd47, 8'h00, 8'hff, 8'hff, 8'hff, 8'hff));
    push_sample(make_sample(8'd48, 8'd0, 8'h80, 8'h12, 8'h34, 8'h56, 8'h78));
    push_sample(make_sample(8'd0, 8'd48, 8'h80, 8'h12, 8'h34, 8'h56, 8'h78));
    wait_drained();
  endtask

  // Tint at the colour extremes; saturated canvas gives the top pixel index.
  task automatic test_tint_extremes();
    gcb_pkg::cfg_t c;
    c = '{offset_x: 9'sd0, offset_y: 9'sd0, canvas_width: 9'h1ff,
          canvas_height: 9'd300, text_color: 24'h000000, blend_mode: 1'b0};
    set_config(c);
    push_sample(make_sample(8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'h00));
    push_sample(make_sample(8'hff, 8'h00, 8'h00, 8'h9a, 8'h3c, 8'h5e, 8'h10));
    wait_drained();
    c.text_color = 24'hffffff;
    set_config(c);
    push_sample(make_sample(8'h00, 8'hff, 8'hc8, 8'h00, 8'h00, 8'h00, 8'hff));
    push_sample(make_sample(8'h81, 8'h7e, 8'h01, 8'h00, 8'hff, 8'h7f, 8'h01));
    wait_drained();
  endtask

  // Blend at the coverage and alpha extremes, empty coverage included.
  task automatic test_blend_extremes();
    gcb_pkg::cfg_t c;
    c = '{offset_x: 9'sd0, offset_y: 9'sd0, canvas_width: 9'd256,
          canvas_height: 9'd256, text_color: 24'h5a3cc3, blend_mode: 1'b1};
    set_config(c);
    push_sample(make_sample(8'd10, 8'd20, 8'h00, 8'h11, 8'h22, 8'h33, 8'h44));
    push_sample(make_sample(8'd3, 8'd4, 8'hff, 8'h00, 8'h80, 8'hff, 8'h00));
    push_sample(make_sample(8'd5, 8'd6, 8'h01, 8'hff, 8'h00, 8'h80, 8'hff));
    push_sample(make_sample(8'd7, 8'd8, 8'hff, 8'h00, 8'h00, 8'h00, 8'hff));
    push_sample(make_sample(8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff));
    wait_drained();
  endtask

  // Offsets at both ends, empty canvases and a single-pixel canvas.
  task automatic test_clipping();
    gcb_pkg::cfg_t c;
    c = '{offset_x: 9'h100, offset_y: 9'h0ff, canvas_width: 9'd256,
          canvas_height: 9'd256, text_color: 24'h808080, blend_mode: 1'b0};
    set_config(c);
    push_sample(make_sample(8'd0, 8'd255, 8'h40, 8'h01, 8'h02, 8'h03, 8'h04));
    push_sample(make_sample(8'd0, 8'd0, 8'h40, 8'hfe, 8'hfd, 8'hfc, 8'hfb));
    wait_drained();
    c = '{offset_x: 9'h0ff, offset_y: 9'sd0, canvas_width: 9'd256,
          canvas_height: 9'd1, text_color: 24'h808080, blend_mode: 1'b1};
    set_config(c);
    push_sample(make_sample(8'd0, 8'd0, 8'h90, 8'h20, 8'h40, 8'h60, 8'h80));
    push_sample(make_sample(8'd1, 8'd0, 8'h90, 8'h20, 8'h40, 8'h60, 8'h80));
    push_sample(make_sample(8'd0, 8'd1, 8'h90, 8'h20, 8'h40, 8'h60, 8'h80));
    wait_drained();
    c = '{offset_x: 9'sd0, offset_y: 9'sd0, canvas_width: 9'd0,
          canvas_height: 9'd48, text_color: 24'h123456, blend_mode: 1'b0};
    set_config(c);
    push_sample(make_sample(8'd0, 8'd0, 8'hff, 8'h33, 8'h44, 8'h55, 8'h66));
    wait_drained();
    c.canvas_width  = 9'd5;
    c.canvas_height = 9'd0;
    set_config(c);
    push_sample(make_sample(8'd0, 8'd0, 8'hff, 8'h33, 8'h44, 8'h55, 8'h66));
    wait_drained();
    c = '{offset_x: -9'sd3, offset_y: -9'sd2, canvas_width: 9'd1,
          canvas_height: 9'd1, text_color: 24'hff00ff, blend_mode: 1'b0};
    set_config(c);
    push_sample(make_sample(8'd2, 8'd3, 8'h7f, 8'h10, 8'h20, 8'h30, 8'h40));
    push_sample(make_sample(8'd2, 8'd4, 8'h7f, 8'h10, 8'h20, 8'h30, 8'h40));
    push_sample(make_sample(8'd3, 8'd3, 8'h7f, 8'h10, 8'h20, 8'h30, 8'h40));
    wait_drained();
  endtask

  // Hold the output off for a long stretch while words keep coming, so the
  // queue and pipe fill and the input side has to stall.
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_config(random_config(1'($urandom)));
    hold_len = 80;
    hold_seq++;
    repeat (30) push_sample(random_sample());
    wait_drained();
  endtask

  // Random words over several random register settings, both modes in turn.
  task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                     input int phases, input int per_phase);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int ph = 0; ph < phases; ph++) begin
      wait_drained();
      set_config(random_config(1'(ph)));
      repeat (per_phase) push_sample(random_sample());
    end
    wait_drained();
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_tint_extremes();
    test_blend_extremes();
    test_clipping();
    test_random_traffic(18, 66, 5, 110);
    test_random_traffic(66, 18, 5, 110);
    test_random_traffic(0, 0, 5, 110);
    test_backpressure();

    // Let any stray word show up before the verdict.
    wait_drained();
    repeat (12) @(posedge clk_i);
    if (pending_pixels.size() != 0) begin
      report_mismatch("words never returned", pending_pixels.size(), 0);
    end
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
